>>> hdl/sequential_list_engine_top_assert.svh
// assertion macros for the list engine checker
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sle_pkg.sv
`default_nettype none
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 3;
    localparam int FIDX_W   = 6;
    localparam int ICNT_W   = 7;

    typedef enum logic [KIND_W-1:0] {
        REQ_APPEND    = 3'd0,
        REQ_POP       = 3'd1,
        REQ_REMOVE_AT = 3'd2,
        REQ_FIND      = 3'd3,
        REQ_READ_AT   = 3'd4,
        REQ_INSERT_AT = 3'd5,
        REQ_SORTED    = 3'd6,
        REQ_NOP       = 3'd7
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CAPTURE,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } t_cell_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         at;
        logic signed [VAL_W-1:0]  val;
        logic [POS_W-1:0]         pos;
        logic [CNT_W-1:0]         cnt;
    } t_cell_cmd;

endpackage
`default_nettype wire

>>> hdl/sle_req_if.sv
`default_nettype none
interface sle_req_if import sle_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink (input valid, input req_type, input value, input position,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/sle_rsp_if.sv
`default_nettype none
interface sle_rsp_if import sle_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [FIDX_W-1:0]       found_index;
    logic [ICNT_W-1:0]       item_count;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, output status, output read_value, output found_index,
                    output item_count, output is_empty, output is_full, input ready);
    modport sink (input valid, input status, input read_value, input found_index,
                  input item_count, input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

>>> hdl/sle_cell.sv
`default_nettype none
module sle_cell import sle_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_eq,
    output logic                    o_gt
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    r_eq;
    logic                    r_gt;
    logic                    w_live;

    assign w_live = CNT_W'(i_idx) < i_cmd.cnt;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            OP_SHIFT_UP: begin
                if (i_idx == i_cmd.at) begin
                    n_value = i_cmd.val;
                end else if (i_idx > i_cmd.at) begin
                    n_value = i_left;
                end
            end
            OP_SHIFT_DOWN: begin
                if (i_idx >= i_cmd.at) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_cmd.op == OP_CAPTURE) begin
            r_eq <= w_live && (r_value == i_cmd.val);
            r_gt <= w_live && (r_value > i_cmd.val);
        end
    end

    assign o_value = r_value;
    assign o_eq    = r_eq;
    assign o_gt    = r_gt;

endmodule
`default_nettype wire

>>> hdl/sle_ctrl.sv
`default_nettype none
module sle_ctrl import sle_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    sle_req_if.sink                 i_req,
    sle_rsp_if.source               o_rsp,
    input  logic [CAPACITY-1:0]     i_eq,
    input  logic [CAPACITY-1:0]     i_gt,
    input  logic signed [VAL_W-1:0] i_rd_value,
    output t_cell_cmd               o_cmd
);

    t_state                  r_state;
    t_state                  n_state;
    t_req                    r_kind;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_rd;

    logic                    r_out_valid;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_read_value;
    logic [FIDX_W-1:0]       r_found_index;
    logic [ICNT_W-1:0]       r_item_count;
    logic                    r_is_empty;
    logic                    r_is_full;

    logic                    w_accept;
    logic                    w_commit;
    logic [IDX_W-1:0]        w_first_eq;
    logic [IDX_W-1:0]        w_first_gt;
    t_status                 w_status;
    t_cell_op                w_op;
    logic [IDX_W-1:0]        w_at;
    logic [CNT_W-1:0]        w_new_count;
    logic signed [VAL_W-1:0] w_rd;
    logic [IDX_W-1:0]        w_idx;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    // first set flag of the row
    always_comb begin
        w_first_eq = '0;
        w_first_gt = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_eq[i]) begin
                w_first_eq = IDX_W'(i);
            end
            if (i_gt[i]) begin
                w_first_gt = IDX_W'(i);
            end
        end
    end

    always_comb begin
        logic full;
        logic empty;
        logic pos_ge;
        logic pos_gt;
        full        = r_count == CNT_W'(CAPACITY);
        empty       = r_count == '0;
        pos_ge      = WIDE_W'(r_pos) >= WIDE_W'(r_count);
        pos_gt      = WIDE_W'(r_pos) > WIDE_W'(r_count);
        w_status    = ST_OK;
        w_op        = OP_HOLD;
        w_at        = '0;
        w_new_count = r_count;
        w_rd        = '0;
        w_idx       = '0;
        case (r_kind)
            REQ_APPEND: begin
                if (full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op        = OP_SHIFT_UP;
                    w_at        = IDX_W'(r_count);
                    w_new_count = r_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_new_count = r_count - 1'b1;
                end
            end
            REQ_REMOVE_AT: begin
                if (empty) begin
                    w_status = ST_EMPTY;
                end else if (pos_ge) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = OP_SHIFT_DOWN;
                    w_at        = IDX_W'(r_pos);
                    w_new_count = r_count - 1'b1;
                end
            end
            REQ_FIND: begin
                if (|i_eq) begin
                    w_idx = w_first_eq;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            REQ_READ_AT: begin
                if (empty) begin
                    w_status = ST_EMPTY;
                end else if (pos_ge) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd = r_rd;
                end
            end
            REQ_INSERT_AT: begin
                if (full) begin
                    w_status = ST_FULL;
                end else if (pos_gt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op        = OP_SHIFT_UP;
                    w_at        = IDX_W'(r_pos);
                    w_new_count = r_count + 1'b1;
                end
            end
            REQ_SORTED: begin
                if (full) begin
                    w_status = ST_FULL;
                end else begin
                    // no greater entry: goes to the end
                    w_op        = OP_SHIFT_UP;
                    w_at        = (|i_gt) ? w_first_gt : IDX_W'(r_count);
                    w_new_count = r_count + 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_cmd.op    = OP_HOLD;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_CMP: begin
                o_cmd.op = OP_CAPTURE;
            end
            S_UPD: begin
                if (w_commit) begin
                    o_cmd.op = w_op;
                end
            end
            default: begin
                o_cmd.op = OP_HOLD;
            end
        endcase
        o_cmd.at  = w_at;
        o_cmd.val = r_val;
        o_cmd.pos = r_pos;
        o_cmd.cnt = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= w_new_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_req'(i_req.req_type);
            r_val  <= i_req.value;
            r_pos  <= i_req.position;
        end
        if (r_state == S_CMP) begin
            r_rd <= i_rd_value;
        end
        if (w_commit) begin
            r_status      <= w_status;
            r_read_value  <= w_rd;
            r_found_index <= FIDX_W'(w_idx);
            r_item_count  <= ICNT_W'(w_new_count);
            r_is_empty    <= w_new_count == '0;
            r_is_full     <= w_new_count == CNT_W'(CAPACITY);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_value  = r_read_value;
    assign o_rsp.found_index = r_found_index;
    assign o_rsp.item_count  = r_item_count;
    assign o_rsp.is_empty    = r_is_empty;
    assign o_rsp.is_full     = r_is_full;

endmodule
`default_nettype wire

>>> hdl/sequential_list_engine_top.sv
// channel   direction  handshake        payload
// i_req     in         valid / ready    req_type, value, position
// o_rsp     out        valid / ready    status, read_value, found_index, item_count,
//                                       is_empty, is_full
//
// each item goes through accept, compare in every cell, then shift or write plus result
// the result waits in an output register; a stalled output holds the item in its
// last step until the register frees, and no new item is taken until then
// i_rst_n is synchronous and clears the count and control; entries are not cleared
`default_nettype none
module sequential_list_engine_top import sle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sle_req_if.sink   i_req,
    sle_rsp_if.source o_rsp
);

    t_cell_cmd               w_cmd;
    logic signed [VAL_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_gt;
    logic signed [VAL_W-1:0] w_rd_value;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_eq       (w_eq),
        .i_gt       (w_gt),
        .i_rd_value (w_rd_value),
        .o_cmd      (w_cmd)
    );

    // row of cells, each hands its word to its neighbours on a shift
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cmd.val;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        sle_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_eq    (w_eq[g]),
            .o_gt    (w_gt[g])
        );
    end

    assign w_rd_value = w_value[IDX_W'(w_cmd.pos)];

endmodule
`default_nettype wire

>>> hdl/sle_checker.sv
`default_nettype none
`include "sequential_list_engine_top_assert.svh"
module sle_checker import sle_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic                    i_req_ready,
    input  logic                    i_rsp_valid,
    input  logic                    i_rsp_ready,
    input  logic [STAT_W-1:0]       i_status,
    input  logic signed [VAL_W-1:0] i_read_value,
    input  logic [FIDX_W-1:0]       i_found_index,
    input  logic [ICNT_W-1:0]       i_item_count,
    input  logic                    i_is_empty,
    input  logic                    i_is_full
);

    `SLE_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_item_count) && $stable(i_status), "result item dropped or changed while stalled")
    `SLE_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, i_rsp_valid, i_is_empty == (i_item_count == '0), "empty flag disagrees with count")
    `SLE_ASSERT_IMP(a_full_flag, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_FULL), i_is_full, "full status without full flag")
    `SLE_ASSERT_IMP(a_zero_fields, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK), (i_read_value == '0) && (i_found_index == '0), "failed request returns data")
    `SLE_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "new item taken while one is in work")

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_read_value  (o_rsp.read_value),
    .i_found_index (o_rsp.found_index),
    .i_item_count  (o_rsp.item_count),
    .i_is_empty    (o_rsp.is_empty),
    .i_is_full     (o_rsp.is_full)
);
`default_nettype wire
